/* rtl/pzc_pkg.sv */
// Package for the power zone classifier: field widths, zone codes,
// the zone bound table and the shared context struct.
// No dependencies.
`default_nettype none

package pzc_pkg;

    localparam int POWER_W = 16;
    localparam int THR_W   = 11;
    localparam int ZONE_W  = 3;
    localparam int PCT_W   = 10;
    // 20 * 65535 and 307 * 2047 both fit in 21 bits
    localparam int CMP_W   = 21;

    typedef logic [ZONE_W-1:0]  t_zone;
    typedef logic [PCT_W-1:0]   t_pct;
    typedef logic [POWER_W-1:0] t_power;
    typedef logic [THR_W-1:0]   t_thr;
    typedef logic [CMP_W-1:0]   t_cmp;

    localparam t_zone ZONE_NONE = 3'd0;
    localparam t_zone ZONE_FIRST = 3'd1;
    localparam t_zone ZONE_TOP  = 3'd7;

    localparam t_thr THR_RESET = 11'd200;

    // Lower bound of each zone in percent of threshold power
    localparam t_pct ZONE_BOUND_PCT [8] = '{
        10'd0, 10'd0, 10'd55, 10'd76, 10'd91, 10'd106, 10'd121, 10'd151
    };

    // Twice the hysteresis band of 2.5 percent
    localparam t_pct HYST_PCT_X2 = 10'd5;

    typedef struct packed {
        logic  no_history;
        t_zone last_zone;
        t_zone raw_zone;
    } t_zone_ctx;

    function automatic t_cmp scale_thr(input t_pct pct, input t_thr thr);
        return CMP_W'(pct) * CMP_W'(thr);
    endfunction

endpackage

`default_nettype wire

/* rtl/pzc_if.sv */
// Valid/ready channel interfaces for the power zone classifier.
// Depends on pzc_pkg.
`default_nettype none

interface pzc_in_if;
    logic                  valid;
    logic                  ready;
    logic [pzc_pkg::POWER_W-1:0] power_dw;
    logic                  no_history;

    modport source(output valid, output power_dw, output no_history, input ready);
    modport sink(input valid, input power_dw, input no_history, output ready);
endinterface

interface pzc_out_if;
    logic                 valid;
    logic                 ready;
    logic [pzc_pkg::ZONE_W-1:0] zone;
    logic [pzc_pkg::ZONE_W-1:0] raw_zone;

    modport source(output valid, output zone, output raw_zone, input ready);
    modport sink(input valid, input zone, input raw_zone, output ready);
endinterface

`default_nettype wire

/* rtl/pzc_raw_zone.sv */
// Raw zone classification of one power sample against the threshold power.
// Depends on pzc_pkg.
`default_nettype none

module pzc_raw_zone (
    input  wire pzc_pkg::t_power i_power_dw,
    input  wire pzc_pkg::t_thr   i_thr_w,
    output pzc_pkg::t_zone       o_raw_zone
);
    import pzc_pkg::*;

    t_cmp  tenp;
    t_zone above_cnt;

    // Bounds rise with the zone, so the zone is one plus the bounds passed
    always_comb begin
        tenp = CMP_W'({i_power_dw, 3'b000}) + CMP_W'({i_power_dw, 1'b0});
        above_cnt = ZONE_NONE;
        for (int z = 2; z < 8; z++) begin
            if (tenp >= scale_thr(ZONE_BOUND_PCT[3'(z)], i_thr_w)) begin
                above_cnt = above_cnt + ZONE_FIRST;
            end
        end
        if ((i_power_dw == '0) || (i_thr_w == '0)) begin
            o_raw_zone = ZONE_NONE;
        end else begin
            o_raw_zone = above_cnt + ZONE_FIRST;
        end
    end

endmodule

`default_nettype wire

/* rtl/pzc_hyst.sv */
// Hysteresis against the kept zone: holds the previous zone unless the
// sample clears the band of 2.5 percent. Depends on pzc_pkg.
`default_nettype none

module pzc_hyst (
    input  wire pzc_pkg::t_power    i_power_dw,
    input  wire pzc_pkg::t_thr      i_thr_w,
    input  wire pzc_pkg::t_zone_ctx i_ctx,
    output pzc_pkg::t_zone          o_zone
);
    import pzc_pkg::*;

    t_cmp twentyp;
    t_pct up_pct;
    t_pct dn_pct;
    t_cmp up_lim;
    t_cmp dn_lim;

    always_comb begin
        twentyp = CMP_W'({i_power_dw, 4'b0000}) + CMP_W'({i_power_dw, 2'b00});
        // dn_pct wraps for zones below 2, but is only used when last zone >= 2
        up_pct = (ZONE_BOUND_PCT[i_ctx.raw_zone] << 1) + HYST_PCT_X2;
        dn_pct = (ZONE_BOUND_PCT[i_ctx.last_zone] << 1) - HYST_PCT_X2;
        up_lim = scale_thr(up_pct, i_thr_w);
        dn_lim = scale_thr(dn_pct, i_thr_w);

        o_zone = i_ctx.raw_zone;
        if (!i_ctx.no_history && (i_ctx.last_zone != ZONE_NONE) &&
            (i_ctx.raw_zone != ZONE_NONE) && (i_ctx.raw_zone != i_ctx.last_zone)) begin
            if (i_ctx.raw_zone > i_ctx.last_zone) begin
                if (twentyp < up_lim) begin
                    o_zone = i_ctx.last_zone;
                end
            end else begin
                if (twentyp >= dn_lim) begin
                    o_zone = i_ctx.last_zone;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/power_zone_classifier_hysteresis.sv */
// Power zone classifier with hysteresis, top level.
// The sample passes the input register, then the result register, before it can
// transfer as a result. Throughput: one item per cycle while the result is not stalled;
// the kept zone is updated in the same cycle as the result.
// A stalled result holds while the input register can still take one more item.
// Reset (synchronous, active low): both stages empty, threshold 200 W, kept zone 0.
`default_nettype none

module power_zone_classifier_hysteresis (
    input  wire            i_clk,
    input  wire            i_rst_n,
    pzc_in_if.sink         i_in,
    pzc_out_if.source      o_out,
    input  wire            i_cfg_we,
    input  wire pzc_pkg::t_thr i_cfg_data
);
    import pzc_pkg::*;

    logic      r_in_valid;
    t_power    r_power;
    logic      r_no_history;
    t_thr      r_thr;
    t_zone     r_last_zone;
    logic      r_out_valid;
    t_zone     r_zone;
    t_zone     r_raw_zone;

    t_zone     n_raw_zone;
    t_zone     n_zone;
    t_zone_ctx ctx;
    logic      advance;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    assign o_out.valid    = r_out_valid;
    assign o_out.zone     = r_zone;
    assign o_out.raw_zone = r_raw_zone;

    pzc_raw_zone u_raw (
        .i_power_dw (r_power),
        .i_thr_w    (r_thr),
        .o_raw_zone (n_raw_zone)
    );

    always_comb begin
        ctx.no_history = r_no_history;
        ctx.last_zone  = r_last_zone;
        ctx.raw_zone   = n_raw_zone;
    end

    pzc_hyst u_hyst (
        .i_power_dw (r_power),
        .i_thr_w    (r_thr),
        .i_ctx      (ctx),
        .o_zone     (n_zone)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_thr       <= THR_RESET;
            r_last_zone <= ZONE_NONE;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_last_zone <= n_zone;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: load on transfer, no reset
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_power      <= i_in.power_dw;
            r_no_history <= i_in.no_history;
        end
        if (advance) begin
            r_zone     <= n_zone;
            r_raw_zone <= n_raw_zone;
        end
    end

endmodule

`default_nettype wire

/* rtl/pzc_checker.sv */
// Port-level checks for the power zone classifier, bound to the top level.
// Depends on pzc_pkg.
`default_nettype none

module pzc_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_in_ready,
    input wire                 i_out_valid,
    input wire                 i_out_ready,
    input wire pzc_pkg::t_zone i_zone,
    input wire pzc_pkg::t_zone i_raw_zone
);
    import pzc_pkg::*;

    // Reset empties the result stage and opens the input
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_out_valid && i_in_ready))
        else $error("result valid or input blocked after reset");

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_zone) && $stable(i_raw_zone)))
        else $error("stalled result changed");

    // Hysteresis never turns a classified sample into no zone, nor the reverse
    a_zone_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_zone == ZONE_NONE) == (i_raw_zone == ZONE_NONE)))
        else $error("zone and raw zone disagree on no zone");

    // An empty result stage never blocks the input
    a_in_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with result stage empty");

endmodule

bind power_zone_classifier_hysteresis pzc_checker u_pzc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_zone      (o_out.zone),
    .i_raw_zone  (o_out.raw_zone)
);

`default_nettype wire

/* tb/tb_power_zone_classifier_hysteresis.sv */
// Self-checking testbench for power_zone_classifier_hysteresis: directed zone
// boundaries and hysteresis moves, then random traffic under varied stalls.
// Depends on pzc_pkg, pzc_if and the classifier top level.

module tb_power_zone_classifier_hysteresis;

    import pzc_pkg::*;

    localparam int unsigned ZONE_LOW_PCT [8] = '{0, 0, 55, 76, 91, 106, 121, 151};
    localparam int unsigned HYST_X2      = 5;
    localparam int          DRAIN_CYCLES = 4;
    localparam int          PRINT_CAP    = 40;

    typedef struct {
        t_zone zone;
        t_zone raw_zone;
    } zone_pair_t;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    t_thr i_cfg_data;

    pzc_in_if  in_ch ();
    pzc_out_if out_ch ();

    power_zone_classifier_hysteresis DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow of the block state and its threshold register
    int unsigned thr_model;
    t_zone       kept_zone;

    zone_pair_t zone_expect_q [$];
    zone_pair_t want_pair;

    int items_sent;
    int results_seen;
    int mismatches;
    int thr_writes;
    int hyst_holds;
    int send_idle_pct;
    int recv_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb_power_zone_classifier_hysteresis: FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < PRINT_CAP) begin
            $display("%0t: mismatch on %s: got %0d, expected %0d (result %0d)",
                     $realtime, what, got, want, results_seen);
        end
        mismatches++;
    endtask

    // Zone from the thresholds, then the hysteresis against the kept zone
    function automatic zone_pair_t predict_zone(input t_power p, input logic bypass);
        zone_pair_t  r;
        int unsigned f;
        int unsigned tenp;
        int unsigned twentyp;
        int          k;
        f       = thr_model;
        tenp    = 10 * int'(p);
        twentyp = 20 * int'(p);
        if (f == 0 || p == 0) begin
            r.raw_zone = ZONE_NONE;
        end else begin
            r.raw_zone = ZONE_FIRST;
            for (k = 2; k <= 7; k++) begin
                if (tenp >= ZONE_LOW_PCT[k] * f) begin
                    r.raw_zone = t_zone'(k);
                end
            end
        end
        r.zone = r.raw_zone;
        if (!bypass && kept_zone != ZONE_NONE && r.raw_zone != ZONE_NONE
                && r.raw_zone != kept_zone) begin
            if (r.raw_zone > kept_zone) begin
                if (twentyp < (2 * ZONE_LOW_PCT[r.raw_zone] + HYST_X2) * f) begin
                    r.zone = kept_zone;
                end
            end else if (twentyp >= (2 * ZONE_LOW_PCT[kept_zone] - HYST_X2) * f) begin
                r.zone = kept_zone;
            end
        end
        if (r.zone != r.raw_zone) begin
            hyst_holds++;
        end
        kept_zone = r.zone;
        return r;
    endfunction

    // Leaves valid high on return so back-to-back items need no second assignment
    task automatic send_sample(input t_power p, input logic bypass);
        if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99, 0) < send_idle_pct);
        end
        in_ch.valid      <= 1'b1;
        in_ch.power_dw   <= p;
        in_ch.no_history <= bypass;
        do @(posedge i_clk); while (!in_ch.ready);
        zone_expect_q.push_back(predict_zone(p, bypass));
        items_sent++;
    endtask

    task automatic wait_results_drained();
        in_ch.valid <= 1'b0;
        while (results_seen < items_sent) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_threshold(input t_thr value);
        wait_results_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        thr_model = value;
        thr_writes++;
    endtask

    // Receiver side: random backpressure at the current rate
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (zone_expect_q.size() == 0) begin
                report_mismatch("unexpected result", out_ch.zone, -1);
            end else begin
                want_pair = zone_expect_q.pop_front();
                if (out_ch.zone !== want_pair.zone) begin
                    report_mismatch("zone", out_ch.zone, want_pair.zone);
                end
                if (out_ch.raw_zone !== want_pair.raw_zone) begin
                    report_mismatch("raw_zone", out_ch.raw_zone, want_pair.raw_zone);
                end
            end
            results_seen++;
        end
    end

    // Every zone edge at the reset threshold of 200 W; the edges of zones 1, 2, 3 and 7 from both sides
    task automatic test_raw_boundaries();
        send_sample(16'd0, 1'b1);
        send_sample(16'd1, 1'b1);
        send_sample(16'd1099, 1'b1);
        send_sample(16'd1100, 1'b1);
        send_sample(16'd1519, 1'b1);
        send_sample(16'd1520, 1'b1);
        send_sample(16'd1820, 1'b1);
        send_sample(16'd2119, 1'b1);
        send_sample(16'd2420, 1'b1);
        send_sample(16'd3019, 1'b1);
        send_sample(16'd3020, 1'b1);
        send_sample(16'hFFFF, 1'b0);
    endtask

    // Hold and move around the 2.5 percent band, then clear the kept zone
    task automatic test_hysteresis_moves();
        send_sample(16'd1200, 1'b1);
        send_sample(16'd1550, 1'b0);
        send_sample(16'd1570, 1'b0);
        send_sample(16'd1480, 1'b0);
        send_sample(16'd1469, 1'b0);
        send_sample(16'd1469, 1'b0);
        send_sample(16'd0, 1'b0);
        send_sample(16'd1550, 1'b0);
        send_sample(16'd3100, 1'b0);
    endtask

    task automatic test_threshold_extremes();
        write_threshold(t_thr'(0));
        send_sample(16'd40000, 1'b0);
        write_threshold(t_thr'(2047));
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'd1, 1'b0);
        write_threshold(t_thr'(1));
        send_sample(16'd1, 1'b0);
        send_sample(16'd16, 1'b0);
    endtask

    function automatic t_thr pick_threshold();
        int unsigned sel;
        sel = $urandom_range(99, 0);
        if (sel < 5)  return t_thr'(0);
        if (sel < 10) return t_thr'(2047);
        if (sel < 15) return t_thr'(1);
        if (sel < 60) return t_thr'($urandom_range(400, 100));
        return t_thr'($urandom_range(2047, 0));
    endfunction

    // Mostly samples close to a zone edge, so that the band decides the zone
    function automatic t_power pick_power();
        int sel;
        int centre;
        int span;
        int val;
        sel = int'($urandom_range(99, 0));
        if (sel < 6)  return '0;
        if (sel < 22) return t_power'($urandom);
        if (sel < 32 || thr_model == 0) return t_power'($urandom_range(40000, 1));
        centre = int'(ZONE_LOW_PCT[$urandom_range(7, 2)] * thr_model / 10);
        span   = int'(thr_model / 2) + 3;
        val    = centre + int'($urandom_range(2 * span, 0)) - span;
        if (val < 1)     val = 1;
        if (val > 65535) val = 65535;
        return t_power'(val);
    endfunction

    task automatic test_random_traffic(input int n_items, input int s_pct, input int r_pct);
        int i;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (i = 0; i < n_items; i++) begin
            if (i % 60 == 0) begin
                write_threshold(pick_threshold());
            end else if ($urandom_range(99, 0) == 0) begin
                wait_results_drained();
            end
            send_sample(pick_power(), ($urandom_range(99, 0) < 15));
        end
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_data       <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.power_dw   <= '0;
        in_ch.no_history <= 1'b0;
        thr_model     = THR_RESET;
        kept_zone     = ZONE_NONE;
        items_sent    = 0;
        results_seen  = 0;
        mismatches    = 0;
        thr_writes    = 0;
        hyst_holds    = 0;
        send_idle_pct = 10;
        recv_idle_pct = 86;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_raw_boundaries();
        test_hysteresis_moves();
        test_threshold_extremes();
        test_random_traffic(450, 10, 86);
        test_random_traffic(450, 86, 10);
        test_random_traffic(450, 0, 0);

        wait_results_drained();
        if (zone_expect_q.size() != 0) begin
            report_mismatch("results left waiting", 0, zone_expect_q.size());
        end
        $display("Ran %0d samples across %0d threshold settings; %0d results checked.",
                 items_sent, thr_writes + 1, results_seen);
        $display("Hysteresis held the previous zone on %0d of them.", hyst_holds);
        if (mismatches == 0) begin
            $display("tb_power_zone_classifier_hysteresis: PASS");
        end else begin
            $display("tb_power_zone_classifier_hysteresis: FAIL");
        end
        $finish;
    end

endmodule
